// ----- rtl/core/arp_request_responder_macros.svh -----
// Assertion macros for the ARP request responder.
`ifndef ARP_REQUEST_RESPONDER_MACROS_SVH
`define ARP_REQUEST_RESPONDER_MACROS_SVH
`ifndef SYNTHESIS
`define ARR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("arp responder: invariant violated");
`define ARR_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("arp responder: sequence violated");
`else
`define ARR_ASSERT(lbl, expr)
`define ARR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- rtl/core/arr_pkg.sv -----
// Types, constants and byte maps of the ARP request responder.
`default_nettype none
package arr_pkg;

    localparam int unsigned HDR_BYTES = 42;
    localparam int unsigned CNT_W     = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 48;

    localparam logic [CNT_W-1:0] CNT_MAX   = 6'd63;
    localparam logic [CNT_W-1:0] LAST_HDR  = 6'd41;
    localparam logic [CNT_W-1:0] TIP_FIRST = 6'd38;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_EN  = 2'd2;

    localparam logic [31:0] OWN_IP_RESET = 32'h0A00_020F;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_MAC,
        SRC_CONST
    } t_src;

    typedef struct packed {
        t_src             kind;
        logic [CNT_W-1:0] idx;
        logic [7:0]       value;
    } t_reply_src;

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } t_hdr_chk;

    function automatic t_reply_src reply_src(input logic [CNT_W-1:0] i);
        t_reply_src s;
        s.kind  = SRC_CONST;
        s.idx   = '0;
        s.value = 8'h00;
        if (i < 6'd6) begin
            s.kind = SRC_MEM;
            s.idx  = i + 6'd22;
        end else if (i < 6'd12) begin
            s.kind = SRC_MAC;
            s.idx  = i - 6'd6;
        end else if (i < 6'd22) begin
            case (i)
                6'd12:   s.value = 8'h08;
                6'd13:   s.value = 8'h06;
                6'd14:   s.value = 8'h00;
                6'd15:   s.value = 8'h01;
                6'd16:   s.value = 8'h08;
                6'd17:   s.value = 8'h00;
                6'd18:   s.value = 8'h06;
                6'd19:   s.value = 8'h04;
                6'd20:   s.value = 8'h00;
                6'd21:   s.value = 8'h02;
                default: s.value = 8'h00;
            endcase
        end else if (i < 6'd28) begin
            s.kind = SRC_MAC;
            s.idx  = i - 6'd22;
        end else if (i < 6'd32) begin
            s.kind = SRC_MEM;
            s.idx  = i + 6'd10;
        end else begin
            s.kind = SRC_MEM;
            s.idx  = i - 6'd10;
        end
        return s;
    endfunction

    function automatic t_hdr_chk hdr_check(input logic [CNT_W-1:0] p);
        t_hdr_chk c;
        c.check = 1'b1;
        case (p)
            6'd12:   c.value = 8'h08;
            6'd13:   c.value = 8'h06;
            6'd14:   c.value = 8'h00;
            6'd15:   c.value = 8'h01;
            6'd16:   c.value = 8'h08;
            6'd17:   c.value = 8'h00;
            6'd18:   c.value = 8'h06;
            6'd19:   c.value = 8'h04;
            6'd20:   c.value = 8'h00;
            6'd21:   c.value = 8'h01;
            default: begin
                c.check = 1'b0;
                c.value = 8'h00;
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] mac_byte(input logic [47:0] mac,
                                            input logic [CNT_W-1:0] k);
        logic [7:0] b;
        case (k)
            6'd0:    b = mac[47:40];
            6'd1:    b = mac[39:32];
            6'd2:    b = mac[31:24];
            6'd3:    b = mac[23:16];
            6'd4:    b = mac[15:8];
            default: b = mac[7:0];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/arp_request_responder.sv -----
// ARP request responder: header capture, verdict and reply frame emission.
//
// Input channel: one received frame word per cycle on i_frame_byte, with
// i_frame_end on the last word; accepted when i_valid is high and o_stall
// low. Output channel: result words on o_valid / i_stall. A matching ARP
// request with sending enabled yields 42 reply words; any other frame yields
// one verdict word with o_carries_byte low. o_run_end marks the last word.
// Configuration: i_cfg_index / i_cfg_data written when i_cfg_valid and
// o_cfg_ready are high; o_cfg_ready is always high.
// Throughput: one input word per cycle while o_stall is low. A result word
// passes the job slot, the header memory read and the output register in
// that order. A reply then streams one word per cycle while i_stall is low.
// Header bytes go into a two-bank memory, so the next frame is received while
// a reply drains; one more finished frame can wait in a pending slot, and
// o_stall rises while that slot is full.
// Reset clears the byte count, job and pending slots and output valid; the
// header memory needs no clearing. A stalled receiver holds the output word
// and freezes the memory read pipeline behind it.
`default_nettype none
`include "arp_request_responder_macros.svh"
module arp_request_responder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output      logic                         o_stall,
    input  wire logic [7:0]                   i_frame_byte,
    input  wire logic                         i_frame_end,
    output      logic                         o_valid,
    input  wire logic                         i_stall,
    output      logic                         o_carries_byte,
    output      logic [7:0]                   o_reply_byte,
    output      logic                         o_run_end,
    output      logic                         o_handled,
    input  wire logic                         i_cfg_valid,
    output      logic                         o_cfg_ready,
    input  wire logic [arr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [arr_pkg::CFG_W-1:0]     i_cfg_data
);
    import arr_pkg::*;

    logic [7:0]       r_mem [0:127];
    logic [7:0]       r_rd_data;

    logic [47:0]      r_own_mac;
    logic [31:0]      r_own_ip;
    logic             r_send_en;

    logic [CNT_W-1:0] r_count;
    logic             r_bad;
    logic [31:0]      r_tip;
    logic             r_wbank;

    logic             r_job_valid;
    logic             r_job_reply;
    logic             r_job_ok;
    logic             r_job_bank;
    logic [CNT_W-1:0] r_idx;

    logic             r_pend_valid;
    logic             r_pend_reply;
    logic             r_pend_ok;
    logic             r_pend_bank;

    logic             r_s1_valid;
    logic             r_s1_from_mem;
    logic [7:0]       r_s1_byte;
    logic             r_s1_carry;
    logic             r_s1_last;
    logic             r_s1_ok;

    logic             r_out_valid;
    logic             r_out_carry;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_ok;

    logic             in_acc;
    logic             frame_done;
    logic             en;
    logic             job_last;
    logic             job_free;
    logic [CNT_W-1:0] n_count;
    logic             n_bad;
    logic [31:0]      n_tip;
    logic             n_ok;
    logic             n_reply;
    t_hdr_chk         chk;
    t_reply_src       src;
    logic [7:0]       iss_byte;
    logic             iss_from_mem;

    assign o_stall     = r_pend_valid;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !r_pend_valid;
    assign frame_done  = in_acc && i_frame_end;
    assign en          = !r_out_valid || !i_stall;
    assign job_last    = r_job_valid && (!r_job_reply || r_idx == LAST_HDR);
    assign job_free    = !r_job_valid || (en && job_last);

    always_comb begin
        chk     = hdr_check(r_count);
        n_bad   = r_bad || (chk.check && (i_frame_byte != chk.value));
        n_tip   = (r_count >= TIP_FIRST && r_count <= LAST_HDR)
                ? {r_tip[23:0], i_frame_byte} : r_tip;
        n_count = (r_count < CNT_MAX) ? r_count + 6'd1 : r_count;
        n_ok    = !n_bad && (r_count >= LAST_HDR) && (n_tip == r_own_ip);
        n_reply = n_ok && r_send_en;
    end

    always_comb begin
        src          = reply_src(r_idx);
        iss_from_mem = 1'b0;
        iss_byte     = 8'h00;
        if (r_job_reply) begin
            case (src.kind)
                SRC_MEM:   iss_from_mem = 1'b1;
                SRC_MAC:   iss_byte     = mac_byte(r_own_mac, src.idx);
                SRC_CONST: iss_byte     = src.value;
                default:   iss_byte     = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && r_count < LAST_HDR + 6'd1) begin
            r_mem[{r_wbank, r_count}] <= i_frame_byte;
        end
        if (en) begin
            r_rd_data <= r_mem[{r_job_bank, src.idx}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= OWN_IP_RESET;
            r_send_en <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                CFG_SEND_EN: r_send_en <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_bad        <= 1'b0;
            r_wbank      <= 1'b0;
            r_job_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // receive side
            if (in_acc) begin
                r_tip <= n_tip;
                if (i_frame_end) begin
                    r_count <= '0;
                    r_bad   <= 1'b0;
                    if (n_reply) begin
                        r_wbank <= !r_wbank;
                    end
                end else begin
                    r_count <= n_count;
                    r_bad   <= n_bad;
                end
            end

            // job slot and pending slot
            if (job_free) begin
                r_idx <= '0;
                if (r_pend_valid) begin
                    r_job_valid  <= 1'b1;
                    r_job_reply  <= r_pend_reply;
                    r_job_ok     <= r_pend_ok;
                    r_job_bank   <= r_pend_bank;
                    r_pend_valid <= 1'b0;
                end else if (frame_done) begin
                    r_job_valid <= 1'b1;
                    r_job_reply <= n_reply;
                    r_job_ok    <= n_ok;
                    r_job_bank  <= r_wbank;
                end else begin
                    r_job_valid <= 1'b0;
                end
            end else begin
                if (en) begin
                    r_idx <= r_idx + 6'd1;
                end
                if (frame_done) begin
                    r_pend_valid <= 1'b1;
                    r_pend_reply <= n_reply;
                    r_pend_ok    <= n_ok;
                    r_pend_bank  <= r_wbank;
                end
            end

            // read stage and output register
            if (en) begin
                r_s1_valid    <= r_job_valid;
                r_s1_from_mem <= iss_from_mem;
                r_s1_byte     <= iss_byte;
                r_s1_carry    <= r_job_reply;
                r_s1_last     <= job_last;
                r_s1_ok       <= r_job_ok;
                r_out_valid   <= r_s1_valid;
                r_out_carry   <= r_s1_carry;
                r_out_byte    <= r_s1_from_mem ? r_rd_data : r_s1_byte;
                r_out_last    <= r_s1_last;
                r_out_ok      <= r_s1_ok;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_carries_byte = r_out_carry;
    assign o_reply_byte   = r_out_byte;
    assign o_run_end      = r_out_last;
    assign o_handled      = r_out_ok;

    `ARR_ASSERT(a_pend_needs_job, !r_pend_valid || r_job_valid)
    `ARR_ASSERT(a_bank_apart,
        !(r_pend_valid && r_pend_reply && r_job_reply) || (r_pend_bank != r_job_bank))
    `ARR_ASSERT(a_idx_range, !(r_job_valid && r_job_reply) || (r_idx <= LAST_HDR))
    `ARR_ASSERT(a_reply_handled, !(o_valid && o_carries_byte) || o_handled)
    `ARR_ASSERT_NEXT(a_done_queued, frame_done, r_job_valid)

endmodule
`default_nettype wire

// ----- tb/arp_request_responder_test.sv -----
// Self-checking testbench for the ARP request responder: frames in, verdicts and replies out.
module arp_request_responder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import arr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [15:0] ETHERTYPE_ARP    = 16'h0806;
    localparam logic [15:0] HW_TYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] ARP_PTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  ARP_HLEN_ETH     = 8'd6;
    localparam logic [7:0]  ARP_PLEN_IPV4    = 8'd4;
    localparam logic [15:0] OPCODE_REQ       = 16'h0001;
    localparam logic [15:0] OPCODE_RSP       = 16'h0002;

    typedef struct packed {
        logic       carries;
        logic [7:0] data;
        logic       last;
        logic       handled;
    } t_result_word;

    typedef enum int {
        BAD_ETYPE,
        BAD_HTYPE,
        BAD_PTYPE,
        BAD_HLEN,
        BAD_PLEN,
        BAD_OPCODE,
        BAD_TARGET,
        BAD_LENGTH
    } t_defect;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic [7:0]           i_frame_byte = 8'h00;
    logic                 i_frame_end  = 1'b0;
    logic                 i_stall      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_OWN_MAC;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_carries_byte;
    logic [7:0]           o_reply_byte;
    logic                 o_run_end;
    logic                 o_handled;
    logic                 o_cfg_ready;

    logic [47:0] cfg_mac  = 48'h0;
    logic [31:0] cfg_ip   = OWN_IP_RESET;
    logic        cfg_send = 1'b0;
    logic [5:0]  cap_count = 6'd0;
    logic [7:0]  cap_hdr [0:HDR_BYTES-1];

    t_result_word due_words[$];
    logic [7:0]   frame_buf[$];

    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned hold_cycles = 0;
    int unsigned stall_left  = 0;
    logic        idle_on     = 1'b1;
    logic        hold_on     = 1'b0;

    arp_request_responder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_frame_byte   (i_frame_byte),
        .i_frame_end    (i_frame_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_carries_byte (o_carries_byte),
        .o_reply_byte   (o_reply_byte),
        .o_run_end      (o_run_end),
        .o_handled      (o_handled),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL arp_request_responder");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        hold_cycles <= hold_on ? hold_cycles + 1 : 0;
    end

    always @(posedge i_clk) begin : stall_gen
        logic burst;
        burst = 1'b0;
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            burst = 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 16);
            burst = 1'b1;
        end
        i_stall <= burst || hold_on;
    end

    // ARP header bytes 12..21 as sent in a request or a reply
    function automatic logic [7:0] arp_head_octet(input int p, input logic is_reply);
        logic [15:0] op;
        op = is_reply ? OPCODE_RSP : OPCODE_REQ;
        case (p)
            12:      return ETHERTYPE_ARP[15:8];
            13:      return ETHERTYPE_ARP[7:0];
            14:      return HW_TYPE_ETHERNET[15:8];
            15:      return HW_TYPE_ETHERNET[7:0];
            16:      return ARP_PTYPE_IPV4[15:8];
            17:      return ARP_PTYPE_IPV4[7:0];
            18:      return ARP_HLEN_ETH;
            19:      return ARP_PLEN_IPV4;
            20:      return op[15:8];
            default: return op[7:0];
        endcase
    endfunction

    function automatic logic [7:0] own_mac_octet(input int k);
        return cfg_mac[8*(5-k) +: 8];
    endfunction

    function automatic logic arp_request_for_us(input int unsigned len);
        int p;
        if (len < HDR_BYTES) return 1'b0;
        for (p = 12; p < 22; p++) begin
            if (cap_hdr[p] != arp_head_octet(p, 1'b0)) return 1'b0;
        end
        return {cap_hdr[38], cap_hdr[39], cap_hdr[40], cap_hdr[41]} == cfg_ip;
    endfunction

    function automatic logic [7:0] reply_octet(input int i);
        if (i < 6)  return cap_hdr[22 + i];
        if (i < 12) return own_mac_octet(i - 6);
        if (i < 22) return arp_head_octet(i, 1'b1);
        if (i < 28) return own_mac_octet(i - 22);
        if (i < 32) return cap_hdr[38 + i - 28];
        if (i < 38) return cap_hdr[22 + i - 32];
        return cap_hdr[28 + i - 38];
    endfunction

    function automatic void absorb_word(input logic [7:0] b, input logic e);
        int unsigned  len;
        logic         ok;
        int           i;
        t_result_word w;
        if (cap_count < HDR_BYTES) cap_hdr[cap_count] = b;
        if (cap_count != CNT_MAX) cap_count = cap_count + 6'd1;
        if (!e) return;
        len = cap_count;
        cap_count = 6'd0;
        ok = arp_request_for_us(len);
        if (ok && cfg_send) begin
            for (i = 0; i < HDR_BYTES; i++) begin
                w.carries = 1'b1;
                w.data    = reply_octet(i);
                w.last    = (i == HDR_BYTES - 1);
                w.handled = 1'b1;
                due_words.push_back(w);
            end
        end else begin
            w.carries = 1'b0;
            w.data    = 8'h00;
            w.last    = 1'b1;
            w.handled = ok;
            due_words.push_back(w);
        end
    endfunction

    function automatic void note_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %02h, got %02h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: carries %0b byte %02h end %0b handled %0b",
                             o_carries_byte, o_reply_byte, o_run_end, o_handled);
            end else begin
                want = due_words.pop_front();
                note_field("carries_byte", 8'(want.carries), 8'(o_carries_byte));
                note_field("reply_byte", want.data, o_reply_byte);
                note_field("run_end", 8'(want.last), 8'(o_run_end));
                note_field("handled", 8'(want.handled), 8'(o_handled));
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_OWN_MAC: cfg_mac  = data[47:0];
            CFG_OWN_IP:  cfg_ip   = data[31:0];
            CFG_SEND_EN: cfg_send = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_frame_byte <= b;
        i_frame_end  <= e;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        absorb_word(b, e);
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame_buf.size(); k++)
            send_word(frame_buf[k], k == frame_buf.size() - 1);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_request(input logic [31:0] tip);
        int k;
        frame_buf.delete();
        for (k = 0; k < HDR_BYTES; k++) frame_buf.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) begin
            for (k = 0; k < 6; k++) frame_buf[k] = 8'hff;
        end
        for (k = 12; k < 22; k++) frame_buf[k] = arp_head_octet(k, 1'b0);
        for (k = 0; k < 4; k++) frame_buf[38 + k] = tip[8*(3-k) +: 8];
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
        end
    endtask

    task automatic flip_bit(input int p);
        frame_buf[p] = frame_buf[p] ^ (8'h01 << $urandom_range(0, 7));
    endtask

    task automatic apply_defect(input t_defect d);
        int len;
        case (d)
            BAD_ETYPE:  flip_bit(12 + $urandom_range(0, 1));
            BAD_HTYPE:  flip_bit(14 + $urandom_range(0, 1));
            BAD_PTYPE:  flip_bit(16 + $urandom_range(0, 1));
            BAD_HLEN:   flip_bit(18);
            BAD_PLEN:   flip_bit(19);
            BAD_OPCODE: flip_bit(20 + $urandom_range(0, 1));
            BAD_TARGET: flip_bit(38 + $urandom_range(0, 3));
            default: begin
                len = $urandom_range(1, HDR_BYTES - 1);
                while (frame_buf.size() > len) void'(frame_buf.pop_back());
            end
        endcase
    endtask

    task automatic build_noise();
        int len;
        len = $urandom_range(1, 70);
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
        if (len > 13 && $urandom_range(0, 1) == 0) begin
            frame_buf[12] = ETHERTYPE_ARP[15:8];
            frame_buf[13] = ETHERTYPE_ARP[7:0];
        end
    endtask

    task automatic send_random_frame();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 9) build_request(cfg_ip);
        else build_noise();
        if (pick == 7 || pick == 8)
            apply_defect(t_defect'($urandom_range(0, BAD_LENGTH)));
        send_frame();
    endtask

    task automatic randomize_registers();
        logic [63:0] junk;
        logic [31:0] ip;
        junk = {$urandom, $urandom};
        ip   = $urandom;
        write_reg(CFG_OWN_MAC, junk[47:0]);
        write_reg(CFG_OWN_IP, {junk[63:48], ip});
        write_reg(CFG_SEND_EN, {junk[47:1], $urandom_range(0, 3) != 0});
    endtask

    task automatic test_reset_settings();
        build_request(OWN_IP_RESET);
        send_frame();
        build_request(OWN_IP_RESET);
        apply_defect(BAD_TARGET);
        send_frame();
        settle();
    endtask

    task automatic test_short_frames();
        frame_buf = '{8'($urandom)};
        send_frame();
        build_noise();
        while (frame_buf.size() > 13) void'(frame_buf.pop_back());
        send_frame();
        build_request(OWN_IP_RESET);
        while (frame_buf.size() > 14) void'(frame_buf.pop_back());
        send_frame();
        build_request(OWN_IP_RESET);
        while (frame_buf.size() > HDR_BYTES - 1) void'(frame_buf.pop_back());
        send_frame();
        settle();
    endtask

    task automatic test_field_checks();
        int d;
        write_reg(CFG_OWN_MAC, 48'h02_1a_c4_5e_90_3b);
        write_reg(CFG_SEND_EN, 48'h1);
        build_request(cfg_ip);
        send_frame();
        for (d = 0; d <= BAD_LENGTH; d++) begin
            build_request(cfg_ip);
            apply_defect(t_defect'(d));
            send_frame();
        end
        build_request(cfg_ip);
        frame_buf[14] = HW_TYPE_ETHERNET[7:0];
        frame_buf[15] = HW_TYPE_ETHERNET[15:8];
        send_frame();
        build_request(cfg_ip);
        frame_buf[20] = OPCODE_RSP[15:8];
        frame_buf[21] = OPCODE_RSP[7:0];
        send_frame();
        build_request(cfg_ip);
        while (frame_buf.size() < 70) frame_buf.push_back(8'($urandom));
        send_frame();
        settle();
    endtask

    task automatic test_register_extremes();
        write_reg(CFG_OWN_MAC, '1);
        write_reg(CFG_OWN_IP, '1);
        build_request(32'hffff_ffff);
        send_frame();
        settle();
        write_reg(CFG_OWN_MAC, '0);
        write_reg(CFG_OWN_IP, '0);
        build_request(32'h0);
        send_frame();
        settle();
        write_reg(CFG_SPARE, 48'({$urandom, $urandom}));
        write_reg(CFG_SEND_EN, '0);
        build_request(32'h0);
        send_frame();
        build_request(32'h0);
        apply_defect(BAD_OPCODE);
        send_frame();
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned phase_start;
        repeat (2) begin
            randomize_registers();
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 80) send_random_frame();
            settle();
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_SEND_EN, 48'h1);
        hold_on <= 1'b1;
        fork
            repeat (4) begin
                build_request(cfg_ip);
                send_frame();
            end
            begin
                while (hold_cycles < LONG_HOLD) @(posedge i_clk);
                hold_on <= 1'b0;
            end
        join
        settle();
    endtask

    task automatic test_back_to_back();
        idle_on <= 1'b0;
        randomize_registers();
        repeat (5) send_random_frame();
        settle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_settings();
        test_short_frames();
        test_field_checks();
        test_register_extremes();
        test_random_frames();
        test_backpressure();
        test_back_to_back();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS arp_request_responder");
        end else begin
            $display("FAIL arp_request_responder");
        end
        $finish;
    end

endmodule
